// File: rtl/core/bbrf_pkg.sv
// ----------------------------------------------------------------------------
// bbrf_pkg
// Shared constants and control types of the box blur row filter.
// ----------------------------------------------------------------------------
package bbrf_pkg;

   localparam int MAX_RADIUS    = 31;
   localparam int MAX_ROW_WIDTH = 4096;
   localparam int LANES         = 4;
   localparam int HIST_DEPTH    = 64;
   localparam int HIST_AW       = 6;
   localparam int POS_W         = 13;
   localparam int SUM_W         = 14;
   localparam int RESULTS_MAX   = 32;

   localparam logic CSR_RADIUS        = 1'b0;
   localparam logic CSR_FOUR_CHANNELS = 1'b1;

   typedef struct packed {
      logic accept;
      logic finish;
      logic start_out;
      logic sum_step;
      logic div_start;
      logic div_step;
      logic load_out;
      logic out_taken;
   } bbrf_cmd_type;

   typedef struct packed {
      logic have_x;
      logic sum_done;
      logic div_done;
   } bbrf_stat_type;

endpackage

// File: rtl/core/bbrf_req_if.sv
// ----------------------------------------------------------------------------
// bbrf_req_if
// Input pixel channel: valid, ready and one pixel with its row flag.
// ----------------------------------------------------------------------------
interface bbrf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] chan0_in;
   logic [7:0] chan1_in;
   logic [7:0] chan2_in;
   logic [7:0] chan3_in;
   logic       row_last_in;

   modport source (output valid, chan0_in, chan1_in, chan2_in, chan3_in, row_last_in,
                   input ready);
   modport sink   (input valid, chan0_in, chan1_in, chan2_in, chan3_in, row_last_in,
                   output ready);
endinterface

// File: rtl/core/bbrf_rsp_if.sv
// ----------------------------------------------------------------------------
// bbrf_rsp_if
// Result channel: valid, ready and one blurred pixel with its flags.
// ----------------------------------------------------------------------------
interface bbrf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] chan0_out;
   logic [7:0] chan1_out;
   logic [7:0] chan2_out;
   logic [7:0] chan3_out;
   logic       run_last;
   logic       row_end_out;

   modport source (output valid, chan0_out, chan1_out, chan2_out, chan3_out, run_last,
                   row_end_out, input ready);
   modport sink   (input valid, chan0_out, chan1_out, chan2_out, chan3_out, run_last,
                   row_end_out, output ready);
endinterface

// File: rtl/core/bbrf_ctrl.sv
// ----------------------------------------------------------------------------
// bbrf_ctrl
// Sequencer: accepts a pixel, then walks every due output through window
// summation, division and delivery.
// ----------------------------------------------------------------------------
module bbrf_ctrl
   import bbrf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  bbrf_stat_type stat,
   output bbrf_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_SUM   = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.have_x) begin
               cmd.start_out = 1'b1;
               state_in      = ST_SUM;
            end else begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_SUM: begin
            if (stat.sum_done) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               cmd.sum_step = 1'b1;
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               cmd.load_out = 1'b1;
               state_in     = ST_OUT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               cmd.out_taken = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/bbrf_datapath.sv
// ----------------------------------------------------------------------------
// bbrf_datapath
// Pixel history memory, row counters, window accumulators, per-lane
// restoring divider and the result register.
// ----------------------------------------------------------------------------
module bbrf_datapath
   import bbrf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  bbrf_cmd_type  cmd,
   output bbrf_stat_type stat,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [4:0]    csr_wdata,
   input  logic [7:0]    pix0,
   input  logic [7:0]    pix1,
   input  logic [7:0]    pix2,
   input  logic [7:0]    pix3,
   input  logic          row_last,
   output logic [7:0]    out0,
   output logic [7:0]    out1,
   output logic [7:0]    out2,
   output logic [7:0]    out3,
   output logic          out_run_last,
   output logic          out_row_end
);

   logic [4:0]       radius_ff;
   logic             four_ff;
   logic [31:0]      hist [HIST_DEPTH];
   logic [31:0]      rd_ff;
   logic [31:0]      first_ff;
   logic             use_first_ff;
   logic             pend_ff;
   logic [POS_W-1:0] pos_ff, emit_ff, p_ff, x_ff;
   logic             last_ff;
   logic [5:0]       n_ff;
   logic [6:0]       k_ff;
   logic [SUM_W-1:0] acc_ff [LANES];
   logic [SUM_W-1:0] num_ff [LANES];
   logic [5:0]       rem_ff [LANES];
   logic [7:0]       quo_ff [LANES];
   logic [3:0]       cnt_ff;
   logic [7:0]       o_ff [LANES];
   logic             run_last_ff, row_end_ff;

   logic [31:0]         pix;
   logic [5:0]          dia;
   logic signed [14:0]  target, xs, idx;
   logic [POS_W-1:0]    sel;
   logic                more;

   assign dia = {radius_ff, 1'b1};
   assign pix = four_ff ? {pix3, pix2, pix1, pix0} : {24'd0, pix0};
   assign xs  = $signed({2'b00, x_ff});
   assign target = last_ff ? $signed({2'b00, p_ff})
                           : $signed({2'b00, p_ff}) - $signed({10'd0, radius_ff});
   assign idx = xs - $signed({10'd0, radius_ff}) + $signed({8'd0, k_ff});

   always_comb begin
      if (idx > $signed({2'b00, p_ff})) begin
         sel = p_ff;
      end else begin
         sel = idx[POS_W-1:0];
      end
   end

   assign stat.have_x   = (xs <= target) && (n_ff < 6'(RESULTS_MAX));
   assign stat.sum_done = (k_ff == {1'b0, dia}) && !pend_ff;
   assign stat.div_done = (cnt_ff == 4'd0);
   assign more = (xs + 15'sd1 <= target) && (n_ff < 6'(RESULTS_MAX - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 5'd1;
         four_ff   <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RADIUS:        radius_ff <= csr_wdata;
            CSR_FOUR_CHANNELS: four_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // History memory: written on accept, read during window summation.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         hist[pos_ff[HIST_AW-1:0]] <= pix;
      end
      rd_ff <= hist[sel[HIST_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         emit_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            if (last_ff) begin
               pos_ff  <= '0;
               emit_ff <= '0;
            end else begin
               pos_ff <= pos_ff + 13'd1;
               if (x_ff > emit_ff) begin
                  emit_ff <= x_ff;
               end
            end
         end
         pend_ff <= cmd.sum_step && (k_ff < {1'b0, dia});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         if (pos_ff == '0) begin
            first_ff <= pix;
         end
         p_ff    <= pos_ff;
         last_ff <= row_last || (pos_ff >= 13'(MAX_ROW_WIDTH - 1));
         x_ff    <= emit_ff;
         n_ff    <= '0;
      end
      if (cmd.out_taken) begin
         x_ff <= x_ff + 13'd1;
         n_ff <= n_ff + 6'd1;
      end
      if (cmd.start_out) begin
         k_ff <= '0;
      end else if (cmd.sum_step && (k_ff < {1'b0, dia})) begin
         k_ff <= k_ff + 7'd1;
      end
      use_first_ff <= (idx <= 15'sd0);
      if (cmd.div_start) begin
         cnt_ff <= 4'(SUM_W);
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff - 4'd1;
      end
      if (cmd.load_out) begin
         run_last_ff <= !more;
         row_end_ff  <= last_ff && (x_ff == p_ff);
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [7:0] byte_v;
      logic [6:0] trial;
      assign byte_v = use_first_ff ? first_ff[8*l +: 8] : rd_ff[8*l +: 8];
      assign trial  = {rem_ff[l], num_ff[l][SUM_W-1]};

      always_ff @(posedge clock) begin
         if (cmd.start_out) begin
            acc_ff[l] <= '0;
         end else if (pend_ff) begin
            acc_ff[l] <= acc_ff[l] + {6'd0, byte_v};
         end
         if (cmd.div_start) begin
            num_ff[l] <= acc_ff[l] + {9'd0, radius_ff};
            rem_ff[l] <= '0;
            quo_ff[l] <= '0;
         end else if (cmd.div_step) begin
            num_ff[l] <= {num_ff[l][SUM_W-2:0], 1'b0};
            if (trial >= {1'b0, dia}) begin
               rem_ff[l] <= 6'(trial - {1'b0, dia});
               quo_ff[l] <= {quo_ff[l][6:0], 1'b1};
            end else begin
               rem_ff[l] <= trial[5:0];
               quo_ff[l] <= {quo_ff[l][6:0], 1'b0};
            end
         end
         if (cmd.load_out) begin
            o_ff[l] <= quo_ff[l];
         end
      end
   end

   assign out0         = o_ff[0];
   assign out1         = o_ff[1];
   assign out2         = o_ff[2];
   assign out3         = o_ff[3];
   assign out_run_last = run_last_ff;
   assign out_row_end  = row_end_ff;

endmodule

// File: rtl/core/box_blur_row_filter_core.sv
// ----------------------------------------------------------------------------
// box_blur_row_filter_core
// One-dimensional box blur of a pixel row, one or four byte channels.
// ----------------------------------------------------------------------------
// Pixels enter on req_ch in row order; row_last_in flags the final pixel.
// Each accepted pixel may release zero to 32 blurred pixels on rsp_ch, the
// last of them marked by run_last; row_end_out marks the row's final output.
// Output x is released when pixel x+r arrives, the rest at the row end.
// Radius and channel mode are written through csr_we/csr_index/csr_wdata;
// the user must write them only while the block is idle, which the block leaves unchecked.
// One item is processed at a time. Per result, a check state is followed by
// window summation (2r+1 reads of the single history memory port, then
// taking in the last read and closing), then the restoring divider, then
// the result register until the result is taken. The next input item
// is accepted once the last result of the current one has been taken.
// If the receiver stalls, the result register and all state simply hold.
// Reset sets radius 1, four channels, and clears the row counters; the
// history memory needs no clearing.
// ----------------------------------------------------------------------------
module box_blur_row_filter_core
   import bbrf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   bbrf_req_if.sink   req_ch,
   bbrf_rsp_if.source rsp_ch,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [4:0] csr_wdata
);

   bbrf_cmd_type  cmd;
   bbrf_stat_type stat;

   bbrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bbrf_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .pix0         (req_ch.chan0_in),
      .pix1         (req_ch.chan1_in),
      .pix2         (req_ch.chan2_in),
      .pix3         (req_ch.chan3_in),
      .row_last     (req_ch.row_last_in),
      .out0         (rsp_ch.chan0_out),
      .out1         (rsp_ch.chan1_out),
      .out2         (rsp_ch.chan2_out),
      .out3         (rsp_ch.chan3_out),
      .out_run_last (rsp_ch.run_last),
      .out_row_end  (rsp_ch.row_end_out)
   );

endmodule
